[hw/rtl/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types, widths and helpers for the contact block decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 104;   // 98 payload bits padded to whole bytes
    localparam int OUT_USER_W = 1;

    localparam logic KIND_CONTACT = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC     = 2'd1;
    localparam logic [1:0] ST_BAD_WIDTH = 2'd2;

    localparam logic [7:0] REP_LIST  = 8'd1;
    localparam logic [7:0] REP_DENSE = 8'd2;

    localparam logic [15:0] SHORT_MISSING = 16'h8000;   // -32768 marks a missing value

    // one queued result word
    typedef struct packed {
        logic               kind;
        logic signed [31:0] bin_first;
        logic signed [31:0] bin_second;
        logic [31:0]        count_bits;
        logic [1:0]         end_status;
        logic               last;
    } result_t;

    function automatic logic not_positive(logic [31:0] v);
        return (v == 32'd0) || v[31];
    endfunction

    // exact single precision bits of a 16-bit two's complement integer
    function automatic logic [31:0] short_to_float(logic [15:0] raw);
        logic        sign;
        logic [15:0] mag;
        logic [3:0]  msb;
        logic [15:0] norm;
        logic [7:0]  expo;
        sign = raw[15];
        mag  = sign ? (~raw + 16'd1) : raw;
        msb  = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (mag[i])
            begin
                msb = 4'(i);
            end
        end
        norm = mag << (4'd15 - msb);
        expo = 8'd127 + {4'd0, msb};
        if (raw == 16'd0)
        begin
            return 32'd0;
        end
        return {sign, expo, norm[14:0], 8'd0};
    endfunction

endpackage

[hw/rtl/contact_block_decoder.sv]
// ----------------------------------------------------------------------------
// contact_block_decoder
// Byte-stream parser for one decompressed contact block; emits contacts and
// an end-of-block report.
// ----------------------------------------------------------------------------
// Each result is written into the result queue at the clock edge that takes its byte.
// Throughput: 1 byte per cycle; s_tready drops only while 3 or 4 words sit in
// the 4-entry result queue (a last byte can queue two words: contact + report).
// Reset: rst_n clears the parser to the record-count field and empties the
// queue; queue payload storage is not reset.
// ----------------------------------------------------------------------------
module contact_block_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave side
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cbd_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // block_last
    // master side
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] bin_first, [63:32] bin_second, [95:64] count_bits,
    // [97:96] end_status, [103:98] zero
    output logic [cbd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [cbd_pkg::OUT_USER_W-1:0] m_tuser,   // [0] result_kind
    output logic                           m_tlast    // last_of_run
);
    import cbd_pkg::*;

    // Parser phases, in stream order
    typedef enum logic [3:0] {
        PH_NREC    = 4'd0,
        PH_XOFF    = 4'd1,
        PH_YOFF    = 4'd2,
        PH_FFLT    = 4'd3,
        PH_FX      = 4'd4,
        PH_FY      = 4'd5,
        PH_REP     = 4'd6,
        PH_LROWS   = 4'd7,
        PH_LROWNUM = 4'd8,
        PH_LCNT    = 4'd9,
        PH_LCOL    = 4'd10,
        PH_LVAL    = 4'd11,
        PH_DCNT    = 4'd12,
        PH_DWID    = 4'd13,
        PH_DVAL    = 4'd14,
        PH_DONE    = 4'd15
    } phase_t;

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    phase_t      phase_reg,        phase_next;
    logic [31:0] assembly_reg,     assembly_next;
    logic [1:0]  byte_idx_reg,     byte_idx_next;
    logic [31:0] x_offset_reg,     x_offset_next;
    logic [31:0] y_offset_reg,     y_offset_next;
    logic [2:0]  flags_reg,        flags_next;      // bit0 float, bit1 wide x, bit2 wide y
    logic [7:0]  rep_reg,          rep_next;
    logic [31:0] rows_left_reg,    rows_left_next;
    logic [31:0] cur_row_reg,      cur_row_next;
    logic [31:0] entries_left_reg, entries_left_next;
    logic [31:0] cur_col_reg,      cur_col_next;
    logic [15:0] dense_width_reg,  dense_width_next;
    logic [15:0] dense_col_reg,    dense_col_next;
    logic [31:0] dense_row_reg,    dense_row_next;

    // ------------------------------------------------------------------
    // Result queue (4 words)
    // ------------------------------------------------------------------
    result_t     queue_reg [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg,  count_next;

    logic        in_fire;
    logic        out_fire;

    assign s_tready = (count_reg <= 3'd2);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 3'd0);
    assign out_fire = m_tvalid && m_tready;

    // ------------------------------------------------------------------
    // Byte parsing
    // ------------------------------------------------------------------
    logic [2:0]  field_len;
    logic [1:0]  last_idx;
    logic [31:0] v_raw;
    logic [31:0] v;
    logic        field_done;
    logic [31:0] rows_dec;
    logic [31:0] entries_dec;
    logic        dense_wok;
    logic        dense_skip;
    logic [15:0] dense_col_inc;
    logic [31:0] value_bits;

    logic        contact_vld;
    result_t     contact;
    result_t     report;
    logic [1:0]  push_n;
    result_t     slot0;
    result_t     slot1;

    always_comb
    begin
        case (phase_reg)
            PH_FFLT, PH_FX, PH_FY, PH_REP: field_len = 3'd1;
            PH_LROWS, PH_LROWNUM:          field_len = flags_reg[2] ? 3'd4 : 3'd2;
            PH_LCNT, PH_LCOL:              field_len = flags_reg[1] ? 3'd4 : 3'd2;
            PH_LVAL, PH_DVAL:              field_len = flags_reg[0] ? 3'd4 : 3'd2;
            PH_DWID:                       field_len = 3'd2;
            default:                       field_len = 3'd4;
        endcase
    end

    assign last_idx   = 2'(field_len - 3'd1);
    assign field_done = (byte_idx_reg == last_idx);
    assign v_raw      = assembly_reg | ({24'd0, s_tdata} << {byte_idx_reg, 3'b000});

    // two-byte counts and indexes are sign extended; values are not
    always_comb
    begin
        if (field_len == 3'd2 && phase_reg != PH_LVAL && phase_reg != PH_DVAL)
        begin
            v = {{16{v_raw[15]}}, v_raw[15:0]};
        end
        else
        begin
            v = v_raw;
        end
    end

    assign rows_dec      = rows_left_reg - 32'd1;
    assign entries_dec   = entries_left_reg - 32'd1;
    assign dense_wok     = (dense_width_reg != 16'd0) && !dense_width_reg[15];
    assign dense_col_inc = dense_col_reg + 16'd1;
    assign value_bits    = flags_reg[0] ? v : short_to_float(v[15:0]);

    // dense filter: NaN or zero for floats, missing or zero for shorts
    always_comb
    begin
        if (flags_reg[0])
        begin
            dense_skip = ((v[30:23] == 8'hFF) && (v[22:0] != 23'd0)) || (v[30:0] == 31'd0);
        end
        else
        begin
            dense_skip = (v[15:0] == SHORT_MISSING) || (v[15:0] == 16'd0);
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        assembly_next     = assembly_reg;
        byte_idx_next     = byte_idx_reg;
        x_offset_next     = x_offset_reg;
        y_offset_next     = y_offset_reg;
        flags_next        = flags_reg;
        rep_next          = rep_reg;
        rows_left_next    = rows_left_reg;
        cur_row_next      = cur_row_reg;
        entries_left_next = entries_left_reg;
        cur_col_next      = cur_col_reg;
        dense_width_next  = dense_width_reg;
        dense_col_next    = dense_col_reg;
        dense_row_next    = dense_row_reg;

        contact_vld         = 1'b0;
        contact.kind        = KIND_CONTACT;
        contact.bin_first   = x_offset_reg + cur_col_reg;
        contact.bin_second  = y_offset_reg + cur_row_reg;
        contact.count_bits  = value_bits;
        contact.end_status  = ST_OK;
        contact.last        = !s_tlast;

        if (phase_reg != PH_DONE)
        begin
            if (!field_done)
            begin
                assembly_next = v_raw;
                byte_idx_next = byte_idx_reg + 2'd1;
            end
            else
            begin
                assembly_next = 32'd0;
                byte_idx_next = 2'd0;
                case (phase_reg)
                    PH_NREC:
                    begin
                        phase_next = PH_XOFF;
                    end
                    PH_XOFF:
                    begin
                        x_offset_next = v;
                        phase_next    = PH_YOFF;
                    end
                    PH_YOFF:
                    begin
                        y_offset_next = v;
                        phase_next    = PH_FFLT;
                    end
                    PH_FFLT:
                    begin
                        flags_next = {2'b00, (v != 32'd0)};
                        phase_next = PH_FX;
                    end
                    PH_FX:
                    begin
                        flags_next = flags_reg | {1'b0, (v != 32'd0), 1'b0};
                        phase_next = PH_FY;
                    end
                    PH_FY:
                    begin
                        flags_next = flags_reg | {(v != 32'd0), 2'b00};
                        phase_next = PH_REP;
                    end
                    PH_REP:
                    begin
                        rep_next = v[7:0];
                        if (v[7:0] == REP_LIST)
                        begin
                            phase_next = PH_LROWS;
                        end
                        else if (v[7:0] == REP_DENSE)
                        begin
                            phase_next = PH_DCNT;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_LROWS:
                    begin
                        rows_left_next = v;
                        phase_next     = not_positive(v) ? PH_DONE : PH_LROWNUM;
                    end
                    PH_LROWNUM:
                    begin
                        cur_row_next = v;
                        phase_next   = PH_LCNT;
                    end
                    PH_LCNT:
                    begin
                        entries_left_next = v;
                        if (not_positive(v))
                        begin
                            rows_left_next = rows_dec;
                            phase_next     = (rows_dec == 32'd0) ? PH_DONE : PH_LROWNUM;
                        end
                        else
                        begin
                            phase_next = PH_LCOL;
                        end
                    end
                    PH_LCOL:
                    begin
                        cur_col_next = v;
                        phase_next   = PH_LVAL;
                    end
                    PH_LVAL:
                    begin
                        contact_vld       = 1'b1;
                        entries_left_next = entries_dec;
                        if (entries_dec == 32'd0)
                        begin
                            rows_left_next = rows_dec;
                            phase_next     = (rows_dec == 32'd0) ? PH_DONE : PH_LROWNUM;
                        end
                        else
                        begin
                            phase_next = PH_LCOL;
                        end
                    end
                    PH_DCNT:
                    begin
                        entries_left_next = v;
                        phase_next        = PH_DWID;
                    end
                    PH_DWID:
                    begin
                        dense_width_next = v[15:0];
                        dense_col_next   = 16'd0;
                        dense_row_next   = 32'd0;
                        phase_next       = not_positive(entries_left_reg) ? PH_DONE : PH_DVAL;
                    end
                    PH_DVAL:
                    begin
                        contact.bin_first  = x_offset_reg + {16'd0, dense_col_reg};
                        contact.bin_second = y_offset_reg + dense_row_reg;
                        if (dense_wok)
                        begin
                            contact_vld = !dense_skip;
                            // wrap the column at the row width
                            if (dense_col_inc == dense_width_reg)
                            begin
                                dense_col_next = 16'd0;
                                dense_row_next = dense_row_reg + 32'd1;
                            end
                            else
                            begin
                                dense_col_next = dense_col_inc;
                            end
                        end
                        entries_left_next = entries_dec;
                        if (entries_dec == 32'd0)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end

        // end-of-block report, judged on the state after this byte
        report.kind       = KIND_REPORT;
        report.bin_first  = 32'sd0;
        report.bin_second = 32'sd0;
        report.count_bits = 32'd0;
        report.last       = 1'b1;
        if (phase_next != PH_DONE)
        begin
            report.end_status = ST_TRUNC;
        end
        else if (rep_next == REP_DENSE &&
                 (dense_width_next == 16'd0 || dense_width_next[15]))
        begin
            report.end_status = ST_BAD_WIDTH;
        end
        else
        begin
            report.end_status = ST_OK;
        end

        // the block is over: back to the header for the next one
        if (s_tlast)
        begin
            phase_next        = PH_NREC;
            assembly_next     = 32'd0;
            byte_idx_next     = 2'd0;
            x_offset_next     = 32'd0;
            y_offset_next     = 32'd0;
            flags_next        = 3'd0;
            rep_next          = 8'd0;
            rows_left_next    = 32'd0;
            cur_row_next      = 32'd0;
            entries_left_next = 32'd0;
            cur_col_next      = 32'd0;
            dense_width_next  = 16'd0;
            dense_col_next    = 16'd0;
            dense_row_next    = 32'd0;
        end
    end

    // pack the words this byte produces: contact first, report after it
    always_comb
    begin
        push_n = 2'd0;
        slot0  = contact_vld ? contact : report;
        slot1  = report;
        if (in_fire)
        begin
            push_n = {1'b0, contact_vld} + {1'b0, s_tlast};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_NREC;
            assembly_reg     <= 32'd0;
            byte_idx_reg     <= 2'd0;
            x_offset_reg     <= 32'd0;
            y_offset_reg     <= 32'd0;
            flags_reg        <= 3'd0;
            rep_reg          <= 8'd0;
            rows_left_reg    <= 32'd0;
            cur_row_reg      <= 32'd0;
            entries_left_reg <= 32'd0;
            cur_col_reg      <= 32'd0;
            dense_width_reg  <= 16'd0;
            dense_col_reg    <= 16'd0;
            dense_row_reg    <= 32'd0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            assembly_reg     <= assembly_next;
            byte_idx_reg     <= byte_idx_next;
            x_offset_reg     <= x_offset_next;
            y_offset_reg     <= y_offset_next;
            flags_reg        <= flags_next;
            rep_reg          <= rep_next;
            rows_left_reg    <= rows_left_next;
            cur_row_reg      <= cur_row_next;
            entries_left_reg <= entries_left_next;
            cur_col_reg      <= cur_col_next;
            dense_width_reg  <= dense_width_next;
            dense_col_reg    <= dense_col_next;
            dense_row_reg    <= dense_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Queue control
    // ------------------------------------------------------------------
    assign wr_ptr_next = wr_ptr_reg + push_n;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, out_fire};
    assign count_next  = count_reg + {1'b0, push_n} - {2'b00, out_fire};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= slot0;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + 2'd1] <= slot1;
        end
    end

    result_t head;
    assign head    = queue_reg[rd_ptr_reg];
    assign m_tdata = {6'd0, head.end_status, head.count_bits, head.bin_second, head.bin_first};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for contact_block_decoder. Byte streams of whole,
// cut-short and malformed contact blocks go in on the slave side. A byte-level
// decoder in the bench works out the contact and report words that each
// accepted byte should raise. Every word taken on the master side is checked
// against the oldest word still awaited. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    import cbd_pkg::*;

    // parser position inside a block
    typedef enum bit [3:0]
    {
        P_NREC, P_XOFF, P_YOFF, P_FLOAT, P_WIDE_X, P_WIDE_Y, P_REP,
        P_ROWS, P_ROW_NUM, P_ENTRY_CNT, P_COLUMN, P_LIST_VAL,
        P_DENSE_CNT, P_DENSE_WID, P_DENSE_VAL, P_DONE
    } parse_phase_t;

    // ------------------------------------------------------------------------
    // Decoder model plus the queue of words it still waits for
    // ------------------------------------------------------------------------
    class contact_predictor;
        parse_phase_t phase;
        bit [31:0]    acc;
        int           idx;
        bit [31:0]    xoff, yoff;
        bit [2:0]     flags;      // [0] float values, [1] wide x, [2] wide y
        bit [7:0]     rep;
        bit [31:0]    rows_left, cur_row, entries_left, cur_col;
        bit [15:0]    dwidth, dcol;
        bit [31:0]    drow;
        result_t      awaited_words[$];
        int           errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase        = P_NREC;
            acc          = '0;
            idx          = 0;
            xoff         = '0;
            yoff         = '0;
            flags        = '0;
            rep          = '0;
            rows_left    = '0;
            cur_row      = '0;
            entries_left = '0;
            cur_col      = '0;
            dwidth       = '0;
            dcol         = '0;
            drow         = '0;
        endfunction

        function int field_bytes();
            case (phase)
                P_FLOAT, P_WIDE_X, P_WIDE_Y, P_REP: return 1;
                P_ROWS, P_ROW_NUM:                  return flags[2] ? 4 : 2;
                P_ENTRY_CNT, P_COLUMN:              return flags[1] ? 4 : 2;
                P_LIST_VAL, P_DENSE_VAL:            return flags[0] ? 4 : 2;
                P_DENSE_WID:                        return 2;
                default:                            return 4;
            endcase
        endfunction

        function bit non_positive(bit [31:0] v);
            return (v == 0) || v[31];
        endfunction

        // short integer to single precision, exact
        function bit [31:0] short_bits(bit [15:0] raw);
            bit [16:0] mag;
            bit [31:0] shifted;
            int        e;
            if (raw == 16'd0)
            begin
                return 32'd0;
            end
            mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
            e = 16;
            while (!mag[e])
            begin
                e--;
            end
            shifted = 32'(mag) << (23 - e);
            return {raw[15], 8'(127 + e), shifted[22:0]};
        endfunction

        function result_t contact(bit [31:0] b1, bit [31:0] b2, bit [31:0] bits);
            result_t r;
            r.kind       = KIND_CONTACT;
            r.bin_first  = b1;
            r.bin_second = b2;
            r.count_bits = bits;
            r.end_status = ST_OK;
            r.last       = 1'b0;
            return r;
        endfunction

        function void finish_row();
            rows_left--;
            phase = (rows_left == 0) ? P_DONE : P_ROW_NUM;
        endfunction

        // one accepted byte: queue whatever words it should raise
        function void decode_byte(bit [7:0] b, bit is_last);
            result_t   made[$];
            result_t   rep_word;
            bit [31:0] v;
            bit [31:0] bits;
            bit        width_ok;
            bit        drop;
            int        len;
            if (phase != P_DONE)
            begin
                len = field_bytes();
                v = acc | (32'(b) << (8 * idx));
                if (idx + 1 < len)
                begin
                    acc = v;
                    idx++;
                end
                else
                begin
                    acc = '0;
                    idx = 0;
                    // 16-bit counts and indexes are signed; values stay raw
                    if (len == 2 && phase != P_LIST_VAL && phase != P_DENSE_VAL)
                    begin
                        v = {{16{v[15]}}, v[15:0]};
                    end
                    case (phase)
                        P_NREC: phase = P_XOFF;
                        P_XOFF:
                        begin
                            xoff  = v;
                            phase = P_YOFF;
                        end
                        P_YOFF:
                        begin
                            yoff  = v;
                            phase = P_FLOAT;
                        end
                        P_FLOAT:
                        begin
                            flags = {2'b00, v != 0};
                            phase = P_WIDE_X;
                        end
                        P_WIDE_X:
                        begin
                            if (v != 0)
                            begin
                                flags[1] = 1'b1;
                            end
                            phase = P_WIDE_Y;
                        end
                        P_WIDE_Y:
                        begin
                            if (v != 0)
                            begin
                                flags[2] = 1'b1;
                            end
                            phase = P_REP;
                        end
                        P_REP:
                        begin
                            rep   = v[7:0];
                            phase = (rep == REP_LIST) ? P_ROWS :
                                    (rep == REP_DENSE) ? P_DENSE_CNT : P_DONE;
                        end
                        P_ROWS:
                        begin
                            rows_left = v;
                            phase = non_positive(v) ? P_DONE : P_ROW_NUM;
                        end
                        P_ROW_NUM:
                        begin
                            cur_row = v;
                            phase   = P_ENTRY_CNT;
                        end
                        P_ENTRY_CNT:
                        begin
                            entries_left = v;
                            if (non_positive(v))
                            begin
                                finish_row();
                            end
                            else
                            begin
                                phase = P_COLUMN;
                            end
                        end
                        P_COLUMN:
                        begin
                            cur_col = v;
                            phase   = P_LIST_VAL;
                        end
                        P_LIST_VAL:
                        begin
                            // list values are never filtered
                            bits = flags[0] ? v : short_bits(v[15:0]);
                            made = {made, contact(xoff + cur_col, yoff + cur_row, bits)};
                            entries_left--;
                            if (entries_left == 0)
                            begin
                                finish_row();
                            end
                            else
                            begin
                                phase = P_COLUMN;
                            end
                        end
                        P_DENSE_CNT:
                        begin
                            entries_left = v;
                            phase        = P_DENSE_WID;
                        end
                        P_DENSE_WID:
                        begin
                            dwidth = v[15:0];
                            dcol   = '0;
                            drow   = '0;
                            phase  = non_positive(entries_left) ? P_DONE : P_DENSE_VAL;
                        end
                        P_DENSE_VAL:
                        begin
                            width_ok = (dwidth != 0) && !dwidth[15];
                            if (flags[0])
                            begin
                                bits = v;
                                // NaN or signed zero
                                drop = ((v[30:23] == 8'hFF) && (v[22:0] != 0)) ||
                                       (v[30:0] == 0);
                            end
                            else
                            begin
                                bits = short_bits(v[15:0]);
                                drop = (v[15:0] == SHORT_MISSING) || (v[15:0] == 0);
                            end
                            if (width_ok)
                            begin
                                if (!drop)
                                begin
                                    made = {made, contact(xoff + 32'(dcol),
                                                          yoff + drow, bits)};
                                end
                                dcol = dcol + 16'd1;
                                if (dcol == dwidth)
                                begin
                                    dcol = '0;
                                    drow++;
                                end
                            end
                            entries_left--;
                            if (entries_left == 0)
                            begin
                                phase = P_DONE;
                            end
                        end
                        default: phase = P_DONE;
                    endcase
                end
            end
            if (is_last)
            begin
                rep_word            = contact('0, '0, '0);
                rep_word.kind       = KIND_REPORT;
                if (phase != P_DONE)
                begin
                    rep_word.end_status = ST_TRUNC;
                end
                else if (rep == REP_DENSE && (dwidth == 0 || dwidth[15]))
                begin
                    rep_word.end_status = ST_BAD_WIDTH;
                end
                made = {made, rep_word};
                clear();
            end
            if (made.size() > 0)
            begin
                made[made.size() - 1].last = 1'b1;
            end
            awaited_words = {awaited_words, made};
        endfunction

        function void field_check(string name, bit [31:0] exp_v, bit [31:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] data, logic kind, logic tl);
            result_t e;
            if (awaited_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %h kind %b",
                         $time, data, kind);
                return;
            end
            e = awaited_words.pop_front();
            field_check("result_kind", 32'(e.kind), 32'(kind));
            field_check("bin_first", e.bin_first, data[31:0]);
            field_check("bin_second", e.bin_second, data[63:32]);
            field_check("count_bits", e.count_bits, data[95:64]);
            field_check("end_status", 32'(e.end_status), 32'(data[97:96]));
            field_check("last_of_run", 32'(e.last), 32'(tl));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] data_byte
    logic                  s_tlast = 1'b0; // block_last
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [31:0] bin_first, [63:32] bin_second, [95:64] count_bits, [97:96] end_status
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;        // [0] result_kind
    logic                  m_tlast;        // last_of_run

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    contact_block_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    contact_predictor predictor;
    bit [7:0]         block_bytes[$];  // block being built
    int               bytes_sent = 0;
    bit               sender_calm = 1'b0;
    bit               receiver_calm = 1'b0;

    // mostly short idles, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 2);
        end
        if (r < 92)
        begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(12, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Master side: random back-pressure, scoring at the rising edge
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int cyc;
        stall_left = 0;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 150 == 0)
            begin
                receiver_calm = ($urandom_range(0, 3) == 0);
            end
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if (!receiver_calm && $urandom_range(0, 99) < 25)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            predictor.check_word(m_tdata, m_tuser[0], m_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Slave side driving and block building
    // ------------------------------------------------------------------------
    // entered right after a falling edge; leaves right after one, valid still up
    task automatic send_byte(bit [7:0] b, bit is_last);
        int gap;
        gap = (!sender_calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = is_last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predictor.decode_byte(b, is_last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_block();
        foreach (block_bytes[i])
        begin
            send_byte(block_bytes[i], i == block_bytes.size() - 1);
        end
        block_bytes.delete();
    endtask

    // little endian, low n bytes of v
    function automatic void push_field(bit [31:0] v, int n);
        for (int i = 0; i < n; i++)
        begin
            block_bytes = {block_bytes, v[8*i +: 8]};
        end
    endfunction

    function automatic bit [31:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFF0 + $urandom_range(0, 15);
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [31:0] pick_value(bit is_float);
        int r;
        r = $urandom_range(0, 9);
        if (is_float)
        begin
            case (r)
                0: return 32'h0000_0000;
                1: return 32'h8000_0000;
                2: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
                3: return {1'($urandom), 31'h7F80_0000};
                default: return $urandom;
            endcase
        end
        case (r)
            0: return 32'h0000;
            1: return 32'(SHORT_MISSING);
            2: return 32'h7FFF;
            3: return 32'h8001;
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    function automatic void push_header(bit fl, bit fx, bit fy, bit [7:0] rep);
        push_field($urandom, 4);
        push_field(pick_offset(), 4);
        push_field(pick_offset(), 4);
        push_field(fl ? $urandom_range(1, 255) : 0, 1);
        push_field(fx ? $urandom_range(1, 255) : 0, 1);
        push_field(fy ? $urandom_range(1, 255) : 0, 1);
        push_field(32'(rep), 1);
    endfunction

    // list of rows; odd_counts brings zero and negative counts in
    function automatic void build_list(bit odd_counts);
        bit fl, fx, fy;
        int rows, cnt;
        fl = $urandom;
        fx = $urandom;
        fy = $urandom;
        push_header(fl, fx, fy, REP_LIST);
        if (odd_counts && $urandom_range(0, 1))
        begin
            push_field($urandom_range(0, 1) ? 32'd0 : (32'h8000_0000 | $urandom), fy ? 4 : 2);
            return;
        end
        rows = $urandom_range(1, 3);
        push_field(rows, fy ? 4 : 2);
        for (int r = 0; r < rows; r++)
        begin
            push_field($urandom, fy ? 4 : 2);
            if (odd_counts && $urandom_range(0, 2) == 0)
            begin
                push_field($urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF, fx ? 4 : 2);
                continue;
            end
            cnt = $urandom_range(1, 3);
            push_field(cnt, fx ? 4 : 2);
            for (int c = 0; c < cnt; c++)
            begin
                push_field($urandom, fx ? 4 : 2);
                push_field(pick_value(fl), fl ? 4 : 2);
            end
        end
    endfunction

    function automatic void build_dense(bit bad_width, bit odd_counts);
        bit fl;
        int cnt;
        fl = $urandom;
        push_header(fl, $urandom, $urandom, REP_DENSE);
        if (odd_counts)
        begin
            push_field($urandom_range(0, 1) ? 32'd0 : (32'h8000_0000 | $urandom), 4);
            push_field($urandom_range(0, 5), 2);
            return;
        end
        cnt = $urandom_range(1, 10);
        push_field(cnt, 4);
        if (bad_width)
        begin
            push_field($urandom_range(0, 1) ? 32'd0 : (32'h8000 | $urandom_range(0, 16'h7FFF)), 2);
        end
        else
        begin
            push_field($urandom_range(0, 7) == 0 ? 16'h7FFF : $urandom_range(1, 4), 2);
        end
        for (int i = 0; i < cnt; i++)
        begin
            push_field(pick_value(fl), fl ? 4 : 2);
        end
    endfunction

    task automatic send_random_block();
        int k;
        int keep;
        sender_calm = ($urandom_range(0, 3) == 0);
        k = $urandom_range(0, 99);
        if (k < 38)
        begin
            build_list(1'b0);
        end
        else if (k < 76)
        begin
            build_dense(1'b0, 1'b0);
        end
        else if (k < 80)
        begin
            build_dense(1'b1, 1'b0);
        end
        else if (k < 84)
        begin
            // any representation but list or dense
            push_header($urandom, $urandom, $urandom,
                        $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(3, 255)));
        end
        else if (k < 89)
        begin
            if ($urandom_range(0, 1))
            begin
                build_list(1'b1);
            end
            else
            begin
                build_dense(1'b0, 1'b1);
            end
        end
        else if (k < 95)
        begin
            // cut short somewhere inside
            if ($urandom_range(0, 1))
            begin
                build_list(1'b0);
            end
            else
            begin
                build_dense(1'b0, 1'b0);
            end
            keep = $urandom_range(1, block_bytes.size() - 1);
            while (block_bytes.size() > keep)
            begin
                void'(block_bytes.pop_back());
            end
        end
        else
        begin
            repeat ($urandom_range(1, 20))
            begin
                block_bytes = {block_bytes, 8'($urandom_range(0, 255))};
            end
        end
        // trailing junk after a complete block is ignored
        if (k < 84 && $urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                block_bytes = {block_bytes, 8'($urandom_range(0, 255))};
            end
        end
        send_block();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        predictor = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single byte block: truncated
        block_bytes = {block_bytes, 8'hA5};
        send_block();

        // dense, short values, width 4 so the row wraps; zero and missing dropped
        push_field(32'd0, 4);
        push_field(32'h7FFF_FFFF, 4);
        push_field(32'h8000_0000, 4);
        push_field(32'd0, 1);
        push_field(32'd0, 1);
        push_field(32'd0, 1);
        push_field(32'(REP_DENSE), 1);
        push_field(32'd6, 4);
        push_field(32'd4, 2);
        push_field(32'h0000, 2);
        push_field(32'h8000, 2);
        push_field(32'h7FFF, 2);
        push_field(32'h8001, 2);
        push_field(32'hFFFF, 2);
        push_field(32'h0001, 2);
        send_block();

        // list, float and wide fields; negative zero and NaN are kept here
        push_field(32'hFFFF_FFFF, 4);
        push_field(32'h8000_0000, 4);
        push_field(32'hFFFF_FFFF, 4);
        push_field(32'h0000_00FF, 1);
        push_field(32'h0000_0080, 1);
        push_field(32'h0000_0001, 1);
        push_field(32'(REP_LIST), 1);
        push_field(32'd1, 4);
        push_field(32'hFFFF_FFFF, 4);
        push_field(32'd2, 4);
        push_field(32'd0, 4);
        push_field(32'h8000_0000, 4);
        push_field(32'h7FFF_FFFF, 4);
        push_field(32'h7FC0_0001, 4);
        send_block();

        while (bytes_sent < 400)
        begin
            send_random_block();
        end
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        while (predictor.awaited_words.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (predictor.awaited_words.size() > 0)
        begin
            predictor.errors++;
            $display("%0t: %0d words never arrived", $time, predictor.awaited_words.size());
        end
        if (predictor.errors == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("testbench NOT OK");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/cbd_pkg.sv
hw/rtl/contact_block_decoder.sv
sim/testbench.sv
